/* rtl/core/tscf_pkg.sv */
// ----------------------------------------------------------------------------
// tscf_pkg: shared types and constants of the TCP SYN cookie filter
// Header, queue item and result layouts, flag masks, codes and table sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package tscf_pkg;

  // Connection table sizing
  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int KEY_W         = 96;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // TCP flag masks and the reserved-bits value that drops a packet
  localparam logic [7:0] FLAG_SYN   = 8'h02;
  localparam logic [7:0] FLAG_ACK   = 8'h10;
  localparam logic [7:0] FLAG_OTHER = 8'hED;
  localparam logic [3:0] RSV_DROP   = 4'd1;

  typedef enum logic [1:0] {
    VERDICT_PASS = 2'd0,
    VERDICT_DROP = 2'd1,
    VERDICT_TX   = 2'd2
  } verdict_t;

  // Header-only class, decided before the table is consulted
  typedef enum logic [1:0] {
    CLS_BAD   = 2'd0,
    CLS_SYN   = 2'd1,
    CLS_ACK   = 2'd2,
    CLS_OTHER = 2'd3
  } cls_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_SCAN = 2'd1,
    BK_LAST = 2'd2,
    BK_DONE = 2'd3
  } bk_state_t;

  typedef struct packed {
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [7:0]  flag_bits;
    logic [3:0]  reserved_bits;
  } hdr_t;

  typedef struct packed {
    hdr_t        hdr;
    cls_t        cls;
    logic [31:0] cookie;
  } item_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [7:0]  flag_bits;
  } res_t;

  // Queue handshake status seen by the back end and the top level
  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

/* rtl/core/tscf_front.sv */
// ----------------------------------------------------------------------------
// tscf_front: header classifier
// Accepts a header beat, computes the cookie and sorts the header into a class.
// ----------------------------------------------------------------------------
`default_nettype none

module tscf_front (
  input  wire logic            start,
  input  wire logic            q_full,
  input  wire tscf_pkg::hdr_t  hdr,
  output logic                 push,
  output tscf_pkg::item_t      item
);

  logic [31:0] cookie;
  logic [31:0] ack_m1;
  logic        syn_f;
  logic        ack_f;
  logic        bad;

  assign cookie = {hdr.sport, hdr.dport} ^ hdr.src_ip ^ hdr.dst_ip;
  assign ack_m1 = hdr.ack_num - 32'd1;
  assign syn_f  = |(hdr.flag_bits & tscf_pkg::FLAG_SYN);
  assign ack_f  = |(hdr.flag_bits & tscf_pkg::FLAG_ACK);
  assign bad    = (syn_f && ack_f) || (hdr.reserved_bits == tscf_pkg::RSV_DROP)
                  || (|(hdr.flag_bits & tscf_pkg::FLAG_OTHER));

  assign push = start && !q_full;

  always_comb begin
    item.hdr    = hdr;
    item.cookie = cookie;
    if (bad) begin
      item.cls = tscf_pkg::CLS_BAD;
    end else if (syn_f) begin
      item.cls = tscf_pkg::CLS_SYN;
    end else if (ack_f && (ack_m1 == cookie)) begin
      item.cls = tscf_pkg::CLS_ACK;
    end else begin
      item.cls = tscf_pkg::CLS_OTHER;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tscf_queue.sv */
// ----------------------------------------------------------------------------
// tscf_queue: two-entry item queue
// Decouples the classifier from the table scan; head stays until popped.
// ----------------------------------------------------------------------------
`default_nettype none

module tscf_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire tscf_pkg::item_t   push_item,
  input  wire logic              pop,
  output tscf_pkg::item_t        head,
  output tscf_pkg::q_stat_t      stat
);

  tscf_pkg::item_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign stat.full      = (count_r == 2'd2);
  assign stat.not_empty = (count_r != 2'd0);
  assign head           = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tscf_back.sv */
// ----------------------------------------------------------------------------
// tscf_back: connection table scan, verdict and header rewrite
// Sweeps the key memory one entry a cycle, then answers and inserts.
// ----------------------------------------------------------------------------
`default_nettype none

module tscf_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tscf_pkg::item_t    head,
  input  wire tscf_pkg::q_stat_t  q_stat,
  output logic                    pop,
  output logic                    res_strobe,
  output tscf_pkg::res_t          res
);

  localparam int IW = tscf_pkg::IDX_W;

  tscf_pkg::bk_state_t state_r, state_nxt;

  logic [tscf_pkg::KEY_W-1:0]       key_mem [tscf_pkg::TABLE_ENTRIES];
  logic [tscf_pkg::TABLE_ENTRIES-1:0] valid_r;

  logic [IW-1:0]              idx_r, idx_nxt;
  logic [IW-1:0]              cmp_idx_r;
  logic [IW-1:0]              free_idx_r;
  logic [tscf_pkg::KEY_W-1:0] rd_key_r;
  logic                       cmp_en_r;
  logic                       hit_r;
  logic                       found_r;
  logic                       rd_en;
  logic                       done;
  logic                       insert;
  logic                       hit_here;
  logic                       free_here;
  logic [tscf_pkg::KEY_W-1:0] key;
  logic                       strobe_r;
  tscf_pkg::res_t             res_r, res_nxt;

  assign key = {head.hdr.src_ip, head.hdr.dst_ip, head.hdr.sport, head.hdr.dport};

  // Sequencer: idle, one read per entry, last compare, answer
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    rd_en     = 1'b0;
    done      = 1'b0;
    unique case (state_r)
      tscf_pkg::BK_IDLE: begin
        if (q_stat.not_empty) begin
          state_nxt = tscf_pkg::BK_SCAN;
          idx_nxt   = '0;
        end
      end
      tscf_pkg::BK_SCAN: begin
        rd_en = 1'b1;
        if (idx_r == tscf_pkg::LAST_IDX) begin
          state_nxt = tscf_pkg::BK_LAST;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      tscf_pkg::BK_LAST: begin
        state_nxt = tscf_pkg::BK_DONE;
      end
      tscf_pkg::BK_DONE: begin
        done      = 1'b1;
        state_nxt = tscf_pkg::BK_IDLE;
      end
      default: begin
        state_nxt = tscf_pkg::BK_IDLE;
      end
    endcase
  end

  assign pop       = done;
  assign hit_here  = cmp_en_r && valid_r[cmp_idx_r] && (rd_key_r == key);
  assign free_here = cmp_en_r && !valid_r[cmp_idx_r];
  assign insert    = done && (head.cls == tscf_pkg::CLS_ACK) && !hit_r && found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tscf_pkg::BK_IDLE;
      idx_r    <= '0;
      cmp_en_r <= 1'b0;
      hit_r    <= 1'b0;
      found_r  <= 1'b0;
      valid_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      cmp_en_r <= rd_en;
      strobe_r <= done;
      if (state_r == tscf_pkg::BK_IDLE) begin
        hit_r   <= 1'b0;
        found_r <= 1'b0;
      end else begin
        if (hit_here) begin
          hit_r <= 1'b1;
        end
        if (free_here && !found_r) begin
          found_r <= 1'b1;
        end
      end
      if (insert) begin
        valid_r[free_idx_r] <= 1'b1;
      end
    end
  end

  // Lowest free slot: the first empty entry met during the sweep
  always_ff @(posedge clk) begin
    if (free_here && !found_r) begin
      free_idx_r <= cmp_idx_r;
    end
    if (rd_en) begin
      cmp_idx_r <= idx_r;
    end
  end

  // Key memory: one registered read port, one write port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key_r <= key_mem[idx_r];
    end
    if (insert) begin
      key_mem[free_idx_r] <= key;
    end
  end

  // Verdict and rewrite
  always_comb begin
    res_nxt.verdict   = tscf_pkg::VERDICT_DROP;
    res_nxt.src_mac   = head.hdr.src_mac;
    res_nxt.dst_mac   = head.hdr.dst_mac;
    res_nxt.src_ip    = head.hdr.src_ip;
    res_nxt.dst_ip    = head.hdr.dst_ip;
    res_nxt.sport     = head.hdr.sport;
    res_nxt.dport     = head.hdr.dport;
    res_nxt.seq_num   = head.hdr.seq_num;
    res_nxt.ack_num   = head.hdr.ack_num;
    res_nxt.flag_bits = head.hdr.flag_bits;
    if (hit_r) begin
      res_nxt.verdict = tscf_pkg::VERDICT_PASS;
    end else begin
      case (head.cls)
        tscf_pkg::CLS_SYN: begin
          res_nxt.verdict   = tscf_pkg::VERDICT_TX;
          res_nxt.seq_num   = head.cookie;
          res_nxt.ack_num   = head.hdr.seq_num + 32'd1;
          res_nxt.flag_bits = head.hdr.flag_bits | tscf_pkg::FLAG_ACK;
        end
        tscf_pkg::CLS_ACK: begin
          res_nxt.verdict   = tscf_pkg::VERDICT_TX;
          res_nxt.seq_num   = head.hdr.ack_num;
          res_nxt.ack_num   = head.hdr.seq_num + 32'd1;
          res_nxt.flag_bits = (head.hdr.flag_bits | tscf_pkg::FLAG_ACK)
                              & ~tscf_pkg::FLAG_SYN;
        end
        default: begin
          res_nxt.verdict = tscf_pkg::VERDICT_DROP;
        end
      endcase
    end
    if (res_nxt.verdict == tscf_pkg::VERDICT_TX) begin
      res_nxt.src_mac = head.hdr.dst_mac;
      res_nxt.dst_mac = head.hdr.src_mac;
      res_nxt.src_ip  = head.hdr.dst_ip;
      res_nxt.dst_ip  = head.hdr.src_ip;
      res_nxt.sport   = head.hdr.dport;
      res_nxt.dport   = head.hdr.sport;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      res_r <= res_nxt;
    end
  end

  assign res_strobe = strobe_r;
  assign res        = res_r;

endmodule

`default_nettype wire

/* rtl/core/tcp_syn_cookie_filter_top.sv */
// ----------------------------------------------------------------------------
// tcp_syn_cookie_filter_top: SYN cookie gate in front of a connection table
// Passes known connections, answers SYNs with cookie SYN-ACKs, admits valid
// cookie ACKs into the table and drops everything else.
// ----------------------------------------------------------------------------
//
//   channel   ports                   beat taken when
//   -------   ---------------------   ------------------------------
//   header    start, busy, in_*       start high and busy low
//   result    out_strobe, out_*       every cycle out_strobe is high
//
// Each header costs the back end a sweep of all TABLE_ENTRIES entries in
// the connection key memory, one entry per cycle through its single read
// port, then a last compare and an answer; the result strobe is registered
// from the answer state. The header under scan stays in the two-entry
// queue until answered, so one further header can be taken while a scan
// runs; busy is high while the queue is full.
// Reset clears the queue, the sequencer and all table valid bits at once,
// so no clearing pass is needed. The receiver cannot stall: each result is
// shown for one cycle only.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_syn_cookie_filter_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [47:0] in_src_mac,
  input  wire logic [47:0] in_dst_mac,
  input  wire logic [31:0] in_src_ip,
  input  wire logic [31:0] in_dst_ip,
  input  wire logic [15:0] in_sport,
  input  wire logic [15:0] in_dport,
  input  wire logic [31:0] in_seq_num,
  input  wire logic [31:0] in_ack_num,
  input  wire logic [7:0]  in_flag_bits,
  input  wire logic [3:0]  in_reserved_bits,
  output logic             out_strobe,
  output logic [1:0]       out_verdict,
  output logic [47:0]      out_src_mac,
  output logic [47:0]      out_dst_mac,
  output logic [31:0]      out_src_ip,
  output logic [31:0]      out_dst_ip,
  output logic [15:0]      out_sport,
  output logic [15:0]      out_dport,
  output logic [31:0]      out_seq_num,
  output logic [31:0]      out_ack_num,
  output logic [7:0]       out_flag_bits
);

  tscf_pkg::hdr_t    hdr;
  tscf_pkg::item_t   front_item;
  tscf_pkg::item_t   head;
  tscf_pkg::q_stat_t q_stat;
  tscf_pkg::res_t    res;
  logic              push;
  logic              pop;

  // Gather the header beat
  always_comb begin
    hdr.src_mac       = in_src_mac;
    hdr.dst_mac       = in_dst_mac;
    hdr.src_ip        = in_src_ip;
    hdr.dst_ip        = in_dst_ip;
    hdr.sport         = in_sport;
    hdr.dport         = in_dport;
    hdr.seq_num       = in_seq_num;
    hdr.ack_num       = in_ack_num;
    hdr.flag_bits     = in_flag_bits;
    hdr.reserved_bits = in_reserved_bits;
  end

  // Hold off new headers only while the queue is full
  assign busy = q_stat.full;

  // Classify header and compute cookie
  tscf_front u_front (
    .start  (start),
    .q_full (q_stat.full),
    .hdr    (hdr),
    .push   (push),
    .item   (front_item)
  );

  // Buffer classified headers between front and back
  tscf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  // Scan table, decide, rewrite, insert
  tscf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .res_strobe (out_strobe),
    .res        (res)
  );

  assign out_verdict   = res.verdict;
  assign out_src_mac   = res.src_mac;
  assign out_dst_mac   = res.dst_mac;
  assign out_src_ip    = res.src_ip;
  assign out_dst_ip    = res.dst_ip;
  assign out_sport     = res.sport;
  assign out_dport     = res.dport;
  assign out_seq_num   = res.seq_num;
  assign out_ack_num   = res.ack_num;
  assign out_flag_bits = res.flag_bits;

endmodule

`default_nettype wire

/* dv/tcp_syn_cookie_filter_checker.sv */
// ----------------------------------------------------------------------------
// tcp_syn_cookie_filter_checker: result predictor and scoreboard
// Watches the header and result channels, keeps a shadow of the connection
// table, predicts each answer at header acceptance and compares field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_syn_cookie_filter_checker
  import tscf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [47:0] in_src_mac,
  input  wire logic [47:0] in_dst_mac,
  input  wire logic [31:0] in_src_ip,
  input  wire logic [31:0] in_dst_ip,
  input  wire logic [15:0] in_sport,
  input  wire logic [15:0] in_dport,
  input  wire logic [31:0] in_seq_num,
  input  wire logic [31:0] in_ack_num,
  input  wire logic [7:0]  in_flag_bits,
  input  wire logic [3:0]  in_reserved_bits,
  input  wire logic        out_strobe,
  input  wire logic [1:0]  out_verdict,
  input  wire logic [47:0] out_src_mac,
  input  wire logic [47:0] out_dst_mac,
  input  wire logic [31:0] out_src_ip,
  input  wire logic [31:0] out_dst_ip,
  input  wire logic [15:0] out_sport,
  input  wire logic [15:0] out_dport,
  input  wire logic [31:0] out_seq_num,
  input  wire logic [31:0] out_ack_num,
  input  wire logic [7:0]  out_flag_bits,
  output int               fail_count,
  output int               pending
);

  localparam int PRINT_CAP = 40;

  // Shadow connection table
  logic        conn_live [TABLE_ENTRIES];
  logic [63:0] conn_addrs[TABLE_ENTRIES];
  logic [31:0] conn_ports[TABLE_ENTRIES];

  res_t answer_q[$];
  res_t oldest;
  hdr_t seen_hdr;

  assign seen_hdr = hdr_t'({in_src_mac, in_dst_mac, in_src_ip, in_dst_ip, in_sport,
                            in_dport, in_seq_num, in_ack_num, in_flag_bits,
                            in_reserved_bits});

  // Work out the answer to one header and update the shadow table.
  function res_t judge_header(input hdr_t h);
    res_t        r;
    logic [63:0] addr_key;
    logic [31:0] port_key;
    logic [31:0] cookie;
    logic        known;
    int          slot;
    addr_key = {h.src_ip, h.dst_ip};
    port_key = {h.sport, h.dport};
    cookie   = port_key ^ h.src_ip ^ h.dst_ip;
    known    = 1'b0;
    slot     = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (conn_live[i] && conn_addrs[i] == addr_key && conn_ports[i] == port_key) begin
        known = 1'b1;
      end
    end

    r.verdict   = VERDICT_DROP;
    r.src_mac   = h.src_mac;
    r.dst_mac   = h.dst_mac;
    r.src_ip    = h.src_ip;
    r.dst_ip    = h.dst_ip;
    r.sport     = h.sport;
    r.dport     = h.dport;
    r.seq_num   = h.seq_num;
    r.ack_num   = h.ack_num;
    r.flag_bits = h.flag_bits;

    if (known) begin
      r.verdict = VERDICT_PASS;
    end else if (((h.flag_bits & FLAG_SYN) != 0 && (h.flag_bits & FLAG_ACK) != 0) ||
                 h.reserved_bits == RSV_DROP || (h.flag_bits & FLAG_OTHER) != 0) begin
      r.verdict = VERDICT_DROP;
    end else if ((h.flag_bits & FLAG_SYN) != 0) begin
      r.verdict   = VERDICT_TX;
      r.seq_num   = cookie;
      r.ack_num   = h.seq_num + 32'd1;
      r.flag_bits = h.flag_bits | FLAG_ACK;
    end else if ((h.flag_bits & FLAG_ACK) != 0 && h.ack_num - 32'd1 == cookie) begin
      // lowest free slot; a full table still answers
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
        if (!conn_live[i]) slot = i;
      end
      if (slot >= 0) begin
        conn_live[slot]  = 1'b1;
        conn_addrs[slot] = addr_key;
        conn_ports[slot] = port_key;
      end
      r.verdict   = VERDICT_TX;
      r.seq_num   = h.ack_num;
      r.ack_num   = h.seq_num + 32'd1;
      r.flag_bits = (h.flag_bits | FLAG_ACK) & ~FLAG_SYN;
    end

    if (r.verdict == VERDICT_TX) begin
      r.src_mac = h.dst_mac;
      r.dst_mac = h.src_mac;
      r.src_ip  = h.dst_ip;
      r.dst_ip  = h.src_ip;
      r.sport   = h.dport;
      r.dport   = h.sport;
    end
    return r;
  endfunction

  task note_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    if (fail_count < PRINT_CAP) begin
      $display("%0t: %s: got %h, want %h", $realtime, what, got, want);
    end
    fail_count++;
  endtask

  task check_field(input string what, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) note_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) conn_live[i] = 1'b0;
      answer_q.delete();
      fail_count = 0;
    end else begin
      if (start && !busy) answer_q.push_back(judge_header(seen_hdr));
      if (out_strobe) begin
        if (answer_q.size() == 0) begin
          note_mismatch("result beat with nothing pending", 64'(out_verdict), '0);
        end else begin
          oldest = answer_q.pop_front();
          check_field("out_verdict",   64'(out_verdict),   64'(oldest.verdict));
          check_field("out_src_mac",   64'(out_src_mac),   64'(oldest.src_mac));
          check_field("out_dst_mac",   64'(out_dst_mac),   64'(oldest.dst_mac));
          check_field("out_src_ip",    64'(out_src_ip),    64'(oldest.src_ip));
          check_field("out_dst_ip",    64'(out_dst_ip),    64'(oldest.dst_ip));
          check_field("out_sport",     64'(out_sport),     64'(oldest.sport));
          check_field("out_dport",     64'(out_dport),     64'(oldest.dport));
          check_field("out_seq_num",   64'(out_seq_num),   64'(oldest.seq_num));
          check_field("out_ack_num",   64'(out_ack_num),   64'(oldest.ack_num));
          check_field("out_flag_bits", 64'(out_flag_bits), 64'(oldest.flag_bits));
        end
      end
    end
    pending = answer_q.size();
  end

endmodule

`default_nettype wire

/* dv/tcp_syn_cookie_filter_top_tb.sv */
// ----------------------------------------------------------------------------
// tcp_syn_cookie_filter_top_tb: stimulus and verdict for the SYN cookie filter
// Drives directed corner headers, then cookie handshakes, known-connection
// traffic and noise over a small key pool, with random and absent idle gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_syn_cookie_filter_top_tb;
  import tscf_pkg::*;

  typedef struct packed {
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] sport;
    logic [15:0] dport;
  } conn_key_t;

  localparam int ITEMS         = 2000;
  // More keys than table slots, so the table fills and later inserts are skipped
  localparam int POOL_SIZE     = 96;
  localparam int GAP_MAX       = 12;
  // Long enough for one back-end sweep of the table, plus the result strobe
  localparam int SETTLE_CYCLES = TABLE_ENTRIES + 16;
  // Worst wait: one queued header behind a running scan, plus a full gap,
  // with a wide margin
  localparam int STALL_LIMIT   = 20 * (TABLE_ENTRIES + 3 + GAP_MAX);

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [47:0] in_src_mac;
  logic [47:0] in_dst_mac;
  logic [31:0] in_src_ip;
  logic [31:0] in_dst_ip;
  logic [15:0] in_sport;
  logic [15:0] in_dport;
  logic [31:0] in_seq_num;
  logic [31:0] in_ack_num;
  logic [7:0]  in_flag_bits;
  logic [3:0]  in_reserved_bits;
  logic        out_strobe;
  logic [1:0]  out_verdict;
  logic [47:0] out_src_mac;
  logic [47:0] out_dst_mac;
  logic [31:0] out_src_ip;
  logic [31:0] out_dst_ip;
  logic [15:0] out_sport;
  logic [15:0] out_dport;
  logic [31:0] out_seq_num;
  logic [31:0] out_ack_num;
  logic [7:0]  out_flag_bits;

  int        fail_count;
  int        pending;
  int        burst_left;
  int        stall_cycles;
  conn_key_t key_pool[POOL_SIZE];

  tcp_syn_cookie_filter_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_src_mac       (in_src_mac),
    .in_dst_mac       (in_dst_mac),
    .in_src_ip        (in_src_ip),
    .in_dst_ip        (in_dst_ip),
    .in_sport         (in_sport),
    .in_dport         (in_dport),
    .in_seq_num       (in_seq_num),
    .in_ack_num       (in_ack_num),
    .in_flag_bits     (in_flag_bits),
    .in_reserved_bits (in_reserved_bits),
    .out_strobe       (out_strobe),
    .out_verdict      (out_verdict),
    .out_src_mac      (out_src_mac),
    .out_dst_mac      (out_dst_mac),
    .out_src_ip       (out_src_ip),
    .out_dst_ip       (out_dst_ip),
    .out_sport        (out_sport),
    .out_dport        (out_dport),
    .out_seq_num      (out_seq_num),
    .out_ack_num      (out_ack_num),
    .out_flag_bits    (out_flag_bits)
  );

  tcp_syn_cookie_filter_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_src_mac       (in_src_mac),
    .in_dst_mac       (in_dst_mac),
    .in_src_ip        (in_src_ip),
    .in_dst_ip        (in_dst_ip),
    .in_sport         (in_sport),
    .in_dport         (in_dport),
    .in_seq_num       (in_seq_num),
    .in_ack_num       (in_ack_num),
    .in_flag_bits     (in_flag_bits),
    .in_reserved_bits (in_reserved_bits),
    .out_strobe       (out_strobe),
    .out_verdict      (out_verdict),
    .out_src_mac      (out_src_mac),
    .out_dst_mac      (out_dst_mac),
    .out_src_ip       (out_src_ip),
    .out_dst_ip       (out_dst_ip),
    .out_sport        (out_sport),
    .out_dport        (out_dport),
    .out_seq_num      (out_seq_num),
    .out_ack_num      (out_ack_num),
    .out_flag_bits    (out_flag_bits),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: end the run when neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[tcp_syn_cookie_filter_top] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [31:0] cookie_for(input conn_key_t k);
    return {k.sport, k.dport} ^ k.sip ^ k.dip;
  endfunction

  // Any reserved value except the one that forces a drop
  function automatic logic [3:0] harmless_rsv();
    logic [3:0] r;
    r = 4'($urandom_range(0, 15));
    if (r == RSV_DROP) r = 4'd0;
    return r;
  endfunction

  // Header on a given key with random MACs and sequence numbers
  function automatic hdr_t make_hdr(input conn_key_t k, input logic [7:0] flags,
                                    input logic [3:0] rsv);
    hdr_t h;
    h.src_mac       = 48'({$urandom, $urandom});
    h.dst_mac       = 48'({$urandom, $urandom});
    h.src_ip        = k.sip;
    h.dst_ip        = k.dip;
    h.sport         = k.sport;
    h.dport         = k.dport;
    h.seq_num       = $urandom;
    h.ack_num       = $urandom;
    h.flag_bits     = flags;
    h.reserved_bits = rsv;
    return h;
  endfunction

  // ACK that carries the right cookie for its key
  function automatic hdr_t cookie_ack(input conn_key_t k);
    hdr_t h;
    h         = make_hdr(k, FLAG_ACK, harmless_rsv());
    h.ack_num = cookie_for(k) + 32'd1;
    return h;
  endfunction

  // Drive one header beat: draw an idle gap (or none inside a burst), raise
  // start, hold until the block takes it. Returns at the falling edge after.
  task automatic send_hdr(input hdr_t h);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(8, 40);
      gap        = 0;
    end else begin
      gap = $urandom_range(0, GAP_MAX);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    {in_src_mac, in_dst_mac, in_src_ip, in_dst_ip, in_sport, in_dport, in_seq_num,
     in_ack_num, in_flag_bits, in_reserved_bits} <= h;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  initial begin
    conn_key_t k;
    conn_key_t k_min;
    hdr_t      h;
    int        roll;

    rst_n = 1'b0;
    start = 1'b0;
    {in_src_mac, in_dst_mac, in_src_ip, in_dst_ip, in_sport, in_dport, in_seq_num,
     in_ack_num, in_flag_bits, in_reserved_bits} = '0;
    burst_left = 0;

    // Half the pool are one-bit neighbors of the previous key, so the
    // table match must use every key bit.
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i % 2 == 1) begin
        key_pool[i] = conn_key_t'(key_pool[i-1] ^ (96'd1 << $urandom_range(0, 95)));
      end else begin
        key_pool[i] = conn_key_t'({$urandom, $urandom, $urandom});
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---------------- directed corners ----------------
    k     = '{32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0};
    // cookie of this key is all ones, so its valid ACK number wraps to zero
    k_min = '{32'hFFFF_FFFF, 32'h0, 16'h0, 16'h0};

    send_hdr('0);                                      // no flags: drop
    send_hdr('1);                                      // everything set: drop
    h = make_hdr(k, FLAG_SYN, 4'd0);
    h.seq_num = '1;                                    // answer ack wraps
    send_hdr(h);
    send_hdr(make_hdr(k, FLAG_SYN, 4'd2));             // harmless reserved values
    send_hdr(make_hdr(k, FLAG_SYN, 4'd15));
    send_hdr(make_hdr(k, FLAG_SYN, RSV_DROP));         // reserved one: drop
    send_hdr(make_hdr(k, FLAG_SYN | FLAG_ACK, 4'd0));  // SYN-ACK: drop
    // SYN plus each of the forbidden flags
    for (int b = 0; b < 8; b++) begin
      if (FLAG_OTHER[b]) send_hdr(make_hdr(k, FLAG_SYN | 8'(1 << b), 4'd0));
    end
    h = make_hdr(k, FLAG_ACK, 4'd0);
    h.ack_num = cookie_for(k);                         // off by one: drop
    send_hdr(h);
    send_hdr(cookie_ack(k));                           // admit
    send_hdr(make_hdr(k, 8'hFF, RSV_DROP));            // known: pass despite all
    send_hdr(make_hdr(k, FLAG_SYN | FLAG_ACK, 4'd0));  // known: pass
    h = cookie_ack(k_min);
    h.seq_num = '1;
    send_hdr(h);                                       // admit on wrapped numbers
    send_hdr(make_hdr(k_min, 8'h00, 4'd0));            // known: pass
    h = make_hdr('{k.dip, k.sip, k.dport, k.sport}, FLAG_ACK, 4'd0);
    h.ack_num = cookie_for(k) + 32'd1;                 // mirrored key is unknown
    send_hdr(h);

    // ---------------- random traffic over the key pool ----------------
    for (int n = 0; n < ITEMS; n++) begin
      k    = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
        h = make_hdr(k, FLAG_SYN, harmless_rsv());
      end else if (roll < 50) begin
        h = cookie_ack(k);
      end else if (roll < 70) begin
        // arbitrary flags: passes only on an admitted key
        h = make_hdr(k, 8'($urandom), 4'($urandom));
      end else if (roll < 78) begin
        h = make_hdr(k, FLAG_ACK, harmless_rsv());
      end else if (roll < 86) begin
        h = make_hdr(k, FLAG_SYN, RSV_DROP);
        if ($urandom_range(0, 1) == 1) begin
          h.flag_bits     = FLAG_SYN | FLAG_ACK;
          h.reserved_bits = harmless_rsv();
        end
      end else begin
        // noise: every field random
        h = make_hdr(conn_key_t'({$urandom, $urandom, $urandom}), 8'($urandom),
                     4'($urandom));
      end
      send_hdr(h);
    end
    start <= 1'b0;

    // Drain, then give the back end time to show any stray beat.
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[tcp_syn_cookie_filter_top] OK");
    end else begin
      $display("[tcp_syn_cookie_filter_top] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
rtl/core/tscf_pkg.sv
rtl/core/tscf_front.sv
rtl/core/tscf_queue.sv
rtl/core/tscf_back.sv
rtl/core/tcp_syn_cookie_filter_top.sv
dv/tcp_syn_cookie_filter_checker.sv
dv/tcp_syn_cookie_filter_top_tb.sv
